// ===== rtl/b64_pkg.sv =====
// Package: shared job type, phase enum, character constants and alphabet mapping.
package b64_pkg;

  // Position within a 3-byte group
  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2
  } b64_phase_t;

  // One classified byte: up to four output characters
  typedef struct packed {
    logic [3:0][5:0] sym;      // 6-bit code per character slot
    logic [3:0]      pad;      // slot emits '=' instead of a code
    logic [1:0]      last_idx; // index of the final slot of this job
    logic            fin;      // job ends the blob
  } b64_job_t;

  localparam logic [7:0] PAD_CHAR     = 8'h3D; // '='
  localparam logic [7:0] STD_62_CHAR  = 8'h2B; // '+'
  localparam logic [7:0] STD_63_CHAR  = 8'h2F; // '/'
  localparam logic [7:0] URL_62_CHAR  = 8'h21; // '!'
  localparam logic [7:0] URL_63_CHAR  = 8'h2A; // '*'
  localparam logic [7:0] UPPER_BASE   = 8'h41; // 'A'
  localparam logic [7:0] LOWER_OFFSET = 8'h47; // 'a' - 26
  localparam logic [7:0] DIGIT_OFFSET = 8'h04; // 52 - '0'

  // Register index of the alphabet select
  localparam logic CFG_URL_ALPHABET = 1'b0;

  // Map a 6-bit code to its ASCII character
  function automatic logic [7:0] map6(input logic [5:0] v, input logic url);
    logic [7:0] v8;
    logic [7:0] ch;
    v8 = {2'b00, v};
    if (v < 6'd26) begin
      ch = UPPER_BASE + v8;
    end else if (v < 6'd52) begin
      ch = LOWER_OFFSET + v8;
    end else if (v < 6'd62) begin
      ch = v8 - DIGIT_OFFSET;
    end else if (v == 6'd62) begin
      ch = url ? URL_62_CHAR : STD_62_CHAR;
    end else begin
      ch = url ? URL_63_CHAR : STD_63_CHAR;
    end
    return ch;
  endfunction

endpackage

// ===== rtl/b64_if.sv =====
// Stream interfaces for the raw byte channel and the encoded character channel.
interface b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// ===== rtl/b64_front.sv =====
// Front end: accepts raw bytes, tracks group phase and carry, builds character jobs.
module b64_front (
  input  logic               clk,
  input  logic               rst_n,
  b64_in_if.sink             in_ch,
  input  logic               q_full,
  output logic               q_push,
  output b64_pkg::b64_job_t  q_data
);

  b64_pkg::b64_phase_t phase_r, phase_nxt;
  logic [3:0]          carry_r, carry_nxt;
  logic                accept;
  logic [7:0]          b;
  logic                fin;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign q_push      = accept;
  assign b           = in_ch.data_byte;
  assign fin         = in_ch.final_byte;

  // Next phase and carry
  always_comb begin
    phase_nxt = phase_r;
    carry_nxt = carry_r;
    if (accept) begin
      if (fin) begin
        phase_nxt = b64_pkg::PH_0;
        carry_nxt = 4'd0;
      end else begin
        case (phase_r)
          b64_pkg::PH_1: begin
            phase_nxt = b64_pkg::PH_2;
            carry_nxt = b[3:0];
          end
          b64_pkg::PH_2: begin
            phase_nxt = b64_pkg::PH_0;
            carry_nxt = 4'd0;
          end
          default: begin
            phase_nxt = b64_pkg::PH_1;
            carry_nxt = {2'b00, b[1:0]};
          end
        endcase
      end
    end
  end

  // Split the byte into 6-bit codes and padding slots
  always_comb begin
    q_data          = '0;
    q_data.fin      = fin;
    case (phase_r)
      b64_pkg::PH_1: begin
        q_data.sym[0] = {carry_r[1:0], b[7:4]};
        if (fin) begin
          q_data.sym[1]   = {b[3:0], 2'b00};
          q_data.pad[2]   = 1'b1;
          q_data.last_idx = 2'd2;
        end else begin
          q_data.last_idx = 2'd0;
        end
      end
      b64_pkg::PH_2: begin
        q_data.sym[0]   = {carry_r[3:0], b[7:6]};
        q_data.sym[1]   = b[5:0];
        q_data.last_idx = 2'd1;
      end
      default: begin
        q_data.sym[0] = b[7:2];
        if (fin) begin
          q_data.sym[1]   = {b[1:0], 4'b0000};
          q_data.pad[2]   = 1'b1;
          q_data.pad[3]   = 1'b1;
          q_data.last_idx = 2'd3;
        end else begin
          q_data.last_idx = 2'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= b64_pkg::PH_0;
      carry_r <= 4'd0;
    end else begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule

// ===== rtl/b64_fifo.sv =====
// Job queue between front and back end, show-ahead read.
module b64_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  b64_pkg::b64_job_t  push_data,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output b64_pkg::b64_job_t  head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64_pkg::b64_job_t slot_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = slot_r[rd_ptr_r];

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/b64_back.sv =====
// Back end: walks each job one character per cycle into the output register while not stalled.
module b64_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               url_alphabet,
  input  logic               job_valid,
  input  b64_pkg::b64_job_t  job,
  output logic               job_pop,
  b64_out_if.source          out_ch
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] char_r, char_nxt;
  logic       last_r, last_nxt;
  logic       load;
  logic       at_end;

  assign load    = job_valid && (!valid_r || out_ch.ready);
  assign at_end  = (idx_r == job.last_idx);
  assign job_pop = load && at_end;

  // Pick the next character of the current job
  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = 1'b1;
      char_nxt  = job.pad[idx_r] ? b64_pkg::PAD_CHAR
                                 : b64_pkg::map6(job.sym[idx_r], url_alphabet);
      last_nxt  = job.fin && at_end;
      idx_nxt   = at_end ? 2'd0 : idx_r + 2'd1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.out_char  = char_r;
  assign out_ch.last_char = last_r;

endmodule

// ===== rtl/base64_stream_encoder.sv =====
// Top level: streaming Base64 encoder with padding and selectable alphabet.
//
//  channel | direction | word                         | handshake
//  in_ch   | in        | data_byte[7:0], final_byte   | valid/ready
//  out_ch  | out       | out_char[7:0], last_char     | valid/ready
//  cfg_*   | in        | url_alphabet at address 0    | APB write/read
//
// Bytes are taken in any cycle the job queue has room, so input may arrive
// back to back. The back end emits one character per cycle while out_ch is
// not stalled, so three bytes give four characters; a final byte gives two to four.
// rst_n is synchronous: it clears phase, carry, queue, output valid and the alphabet select.
// An output stall fills the queue and then drops in_ch.ready.
module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  b64_in_if.sink      in_ch,
  b64_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic              url_r, url_nxt;
  logic              q_push, q_full, q_pop, q_not_empty;
  b64_pkg::b64_job_t q_in, q_head;
  logic              sel_url;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign sel_url    = (cfg_paddr[2] == b64_pkg::CFG_URL_ALPHABET);

  always_comb begin
    url_nxt = url_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && sel_url) begin
      url_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      url_r <= 1'b0;
    end else begin
      url_r <= url_nxt;
    end
  end

  assign cfg_prdata = sel_url ? {31'd0, url_r} : 32'd0;

  b64_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  b64_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  b64_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .url_alphabet (url_r),
    .job_valid    (q_not_empty),
    .job          (q_head),
    .job_pop      (q_pop),
    .out_ch       (out_ch)
  );

endmodule

// ===== rtl/b64_checker.sv =====
// Port checker for the encoder output stream, bound to the top level.
module b64_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       last_char
);

  logic [1:0] pos_r;
  logic       take;

  assign take = out_valid && out_ready;

  // Track character position within the 4-character group
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 2'd0;
    end else if (take) begin
      pos_r <= last_char ? 2'd0 : pos_r + 2'd1;
    end
  end

  // Stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last_char))
    else $error("output word changed while stalled");

  // Reset empties the output register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Encoded text ends on a group boundary
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    take && last_char |-> pos_r == 2'd3)
    else $error("last character not at end of group");

  // A non-final pad sits in the third slot of a group
  a_pad_pos: assert property (@(posedge clk) disable iff (!rst_n)
    take && out_char == b64_pkg::PAD_CHAR && !last_char |-> pos_r == 2'd2)
    else $error("padding in wrong position");

endmodule

bind base64_stream_encoder b64_checker u_b64_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.out_char),
  .last_char (out_ch.last_char)
);

// ===== dv/base64_stream_encoder_checker.sv =====
`timescale 1ns / 1ps
// Checker: watches the byte, character and register ports, predicts the encoded text and compares.
module base64_stream_encoder_checker (
  input  logic        clk,
  input  logic        rst_n,
  b64_in_if           in_mon,
  b64_out_if          out_mon,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          chars_pending
);

  localparam logic [2:0] URL_ALPHABET_ADDR = {b64_pkg::CFG_URL_ALPHABET, 2'b00};

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  // Shadow of the encoder state and its register
  b64_pkg::b64_phase_t group_pos;
  logic [3:0]          leftover;
  logic                url_sel;
  enc_char_t           expected_chars[$];
  enc_char_t           want;
  int                  mismatches = 0;

  // Map one 6-bit group to its ASCII character
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return 8'h41 + w;            // 'A'..'Z'
    end else if (v < 6'd52) begin
      return 8'h61 + w - 8'd26;    // 'a'..'z'
    end else if (v < 6'd62) begin
      return 8'h30 + w - 8'd52;    // '0'..'9'
    end else if (v == 6'd62) begin
      return url_sel ? b64_pkg::URL_62_CHAR : b64_pkg::STD_62_CHAR;
    end
    return url_sel ? b64_pkg::URL_63_CHAR : b64_pkg::STD_63_CHAR;
  endfunction

  function automatic void queue_char(input logic [7:0] ch, input logic last);
    enc_char_t e;
    e.ch   = ch;
    e.last = last;
    expected_chars.push_back(e);
  endfunction

  // Work out the characters that one raw byte causes and advance the group position
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    case (group_pos)
      b64_pkg::PH_1: begin
        queue_char(sextet_char({leftover[1:0], b[7:4]}), 1'b0);
        if (fin) begin
          queue_char(sextet_char({b[3:0], 2'b00}), 1'b0);
          queue_char(b64_pkg::PAD_CHAR, 1'b1);
        end else begin
          leftover  = b[3:0];
          group_pos = b64_pkg::PH_2;
        end
      end
      b64_pkg::PH_2: begin
        queue_char(sextet_char({leftover, b[7:6]}), 1'b0);
        queue_char(sextet_char(b[5:0]), fin);
        leftover  = 4'd0;
        group_pos = b64_pkg::PH_0;
      end
      default: begin
        queue_char(sextet_char(b[7:2]), 1'b0);
        if (fin) begin
          queue_char(sextet_char({b[1:0], 4'd0}), 1'b0);
          queue_char(b64_pkg::PAD_CHAR, 1'b0);
          queue_char(b64_pkg::PAD_CHAR, 1'b1);
        end else begin
          leftover  = {2'b00, b[1:0]};
          group_pos = b64_pkg::PH_1;
        end
      end
    endcase
    // a final byte always closes the group
    if (fin) begin
      leftover  = 4'd0;
      group_pos = b64_pkg::PH_0;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      group_pos = b64_pkg::PH_0;
      leftover  = 4'd0;
      url_sel   = 1'b0;
      expected_chars.delete();
    end else begin
      // track register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == URL_ALPHABET_ADDR) begin
        url_sel = cfg_pwdata[0];
      end
      // predict on every accepted byte word
      if (in_mon.valid && in_mon.ready) begin
        encode_byte(in_mon.data_byte, in_mon.final_byte);
      end
      // compare every accepted character word with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (expected_chars.size() == 0) begin
          $error("out_char: expected nothing, got 0x%02h (last_char %0d)",
                 out_mon.out_char, out_mon.last_char);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (out_mon.out_char !== want.ch) begin
            $error("out_char: expected 0x%02h, got 0x%02h", want.ch, out_mon.out_char);
            mismatches++;
          end
          if (out_mon.last_char !== want.last) begin
            $error("last_char: expected %0d, got %0d", want.last, out_mon.last_char);
            mismatches++;
          end
        end
      end
    end
    chars_pending <= expected_chars.size();
    fail_count    <= mismatches;
  end

endmodule

// ===== dv/base64_stream_encoder_test.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, byte and register stimulus, receiver stalls and the verdict.
module base64_stream_encoder_test;

  localparam int         HOLD_CYCLES  = 200;
  localparam int         DRAIN_CYCLES = 12;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         PHASE_BYTES  = 85;
  localparam int         NUM_PHASES   = 5;
  localparam logic [2:0] URL_ALPHABET_ADDR = {b64_pkg::CFG_URL_ALPHABET, 2'b00};

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count;
  int          chars_pending;
  int          cycle_count;
  bit          src_idle;
  bit          sink_idle;
  bit          hold_off_req;

  b64_in_if  in_ch ();
  b64_out_if out_ch ();

  base64_stream_encoder u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  base64_stream_encoder_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_pready    (cfg_pready),
    .fail_count    (fail_count),
    .chars_pending (chars_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Give up after the cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("base64_stream_encoder_test NOT OK");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        out_ch.ready <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one byte word, maybe after an idle burst, and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.final_byte <= fin;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and wait until every predicted character has come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (chars_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready
  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  initial begin
    int         ph;
    int         sent;
    int         blob_len;
    int         k;
    logic [7:0] b;
    logic       url_pick;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= 8'h00;
    in_ch.final_byte <= 1'b0;
    cfg_psel         <= 1'b0;
    cfg_penable      <= 1'b0;
    cfg_pwrite       <= 1'b0;
    cfg_paddr        <= 3'd0;
    cfg_pwdata       <= 32'd0;
    src_idle          = 1'b1;
    sink_idle         = 1'b1;
    hold_off_req      = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed blobs, standard alphabet: one byte (two pads), two bytes (one pad),
    // whole groups, and values 62 and 63
    cfg_write(URL_ALPHABET_ADDR, 32'd0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'hD3, 1'b1);
    wait_drained();

    // Same corners with the URL-friendly alphabet
    cfg_write(URL_ALPHABET_ADDR, 32'd1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hF0, 1'b1);
    send_byte(8'h3E, 1'b1);
    wait_drained();

    // Random blobs: mostly short, a few long; alphabet is set anew for each phase
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      url_pick = (ph == 2) ? 1'($urandom_range(0, 1)) : 1'(ph % 2);
      cfg_write(URL_ALPHABET_ADDR, {31'd0, url_pick});
      // no idling in the last phase
      src_idle  = (ph != NUM_PHASES - 1);
      sink_idle = (ph != NUM_PHASES - 1);
      // long receiver hold-off while bytes keep coming
      if (ph == 1) begin
        hold_off_req = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_BYTES) begin
        blob_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                               : $urandom_range(1, 12);
        for (k = 0; k < blob_len; k++) begin
          case ($urandom_range(0, 7))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = 8'($urandom_range(0, 255));
          endcase
          send_byte(b, k == blob_len - 1);
          sent++;
        end
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("base64_stream_encoder_test OK");
    end else begin
      $display("base64_stream_encoder_test NOT OK");
    end
    $finish;
  end

endmodule
